// ===== rtl/single_source_shortest_path_unit_macros.svh =====
// Assertion macros used by the checker file of the shortest-path unit.
// Depends on a clk and a rst signal in the scope where the macros are used.
`ifndef SINGLE_SOURCE_SHORTEST_PATH_UNIT_MACROS_SVH
`define SINGLE_SOURCE_SHORTEST_PATH_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SSP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ssp check failed");

// Next-cycle implication, disabled while in reset.
`define SSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ssp check failed");

`endif

// ===== rtl/ssp_pkg.sv =====
// Types and constants of the shortest-path unit.
// No dependencies; used by the interfaces, the top level and the checker.
`default_nettype none
package ssp_pkg;
  localparam int VID_W  = 6;
  localparam int CNT_W  = 7;
  localparam int WIN_W  = 16;
  localparam int DIST_W = 22;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  localparam logic OP_ADD_EDGE = 1'b0;
  localparam logic OP_SOLVE    = 1'b1;

  typedef struct packed {
    logic             opcode;
    logic [VID_W-1:0] source_vertex;
    logic [VID_W-1:0] sink_vertex;
    logic [WIN_W-1:0] weight;
  } in_item_t;

  typedef struct packed {
    logic [VID_W-1:0]  vertex_index;
    logic              reachable;
    logic [DIST_W-1:0] distance;
    logic              has_predecessor;
    logic [VID_W-1:0]  predecessor;
    logic              edge_overflow;
    logic              last;
  } out_item_t;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_SCAN     = 7'b0000010,
    ST_RELAX_RD = 7'b0000100,
    ST_RELAX_CK = 7'b0001000,
    ST_RELAX_UP = 7'b0010000,
    ST_OUT_RD   = 7'b0100000,
    ST_OUT_WAIT = 7'b1000000
  } state_t;
endpackage
`default_nettype wire

// ===== rtl/ssp_if.sv =====
// Valid/ready channel interfaces for input and result transactions.
// Depends on ssp_pkg for the payload structs.
`default_nettype none
interface ssp_in_if;
  logic              valid;
  logic              ready;
  ssp_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ssp_out_if;
  logic               valid;
  logic               ready;
  ssp_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/single_source_shortest_path_unit.sv =====
// Dijkstra shortest-path unit: edge store, vertex memory and solve sequencer.
// Depends on ssp_pkg and the channel interfaces in ssp_if.sv.
//
// Usage:
//   items   : input transactions. opcode add-edge appends (source, sink, weight)
//             to the edge store; edges beyond MAX_EDGES are dropped and set the
//             sticky edge_overflow flag.
//             opcode solve runs Dijkstra from source_vertex and then returns one
//             result transaction per active vertex, ascending, last on the final one.
//   results : result transactions, held in an output register until taken.
//   cfg_we / cfg_data : vertex_count register, to be written only while idle by the
//             user; the block itself does not enforce this.
// Operation:
//   add edge: accepted back to back while idle.
//   solve: each pass scans the vertex memory one entry per cycle to find the
//   minimum, then walks the edge store through its single port: edge read,
//   check and, for a qualifying edge, a write back to the vertex memory. Each
//   result then goes through read, load and handshake steps.
//   items.ready is low for the whole solve including result delivery.
// Reset: clears the edge count, overflow flag, marks and vertex_count (to MAX_VERTICES);
//   no clearing pass. A stalled result simply holds; the unit waits.
`default_nettype none
module single_source_shortest_path_unit #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 1024,
  parameter int WEIGHT_BITS  = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  ssp_in_if.sink                         items,
  ssp_out_if.source                      results,
  input  wire logic                      cfg_we,
  input  wire logic [ssp_pkg::CNT_W-1:0] cfg_data
);
  localparam int VW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int EW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ET_W  = $clog2(MAX_EDGES + 1);
  localparam int SUM_W = ((WEIGHT_BITS > ssp_pkg::DIST_W) ? WEIGHT_BITS : ssp_pkg::DIST_W) + 1;
  localparam int EDGE_W = 2 * ssp_pkg::VID_W + WEIGHT_BITS;
  localparam int VMEM_W = ssp_pkg::DIST_W + ssp_pkg::VID_W;
  localparam logic [ssp_pkg::CNT_W-1:0] MAXV_CNT = ssp_pkg::CNT_W'(MAX_VERTICES);
  localparam logic [ET_W-1:0] MAXE_CNT = ET_W'(MAX_EDGES);

  // Memories: edge store and per-vertex {distance, predecessor}
  logic [EDGE_W-1:0] edge_mem [MAX_EDGES];
  logic [VMEM_W-1:0] vert_mem [MAX_VERTICES];

  ssp_pkg::state_t state;
  logic [ssp_pkg::CNT_W-1:0] vertex_count, n_act, n, cnt, rd_v;
  logic [ET_W-1:0]           edge_total, ecnt;
  logic                      overflow;
  logic [MAX_VERTICES-1:0]   reached, settled;
  logic [ssp_pkg::VID_W-1:0] start;
  logic                      rd_pend, found;
  logic [VW-1:0]             best_u;
  logic [ssp_pkg::DIST_W-1:0] best_d, nd;
  logic [ssp_pkg::VID_W-1:0] cur_to;
  logic                      res_valid;
  ssp_pkg::out_item_t        res;

  // Memory ports
  logic              e_we;
  logic [EW-1:0]     e_addr;
  logic [EDGE_W-1:0] e_wdata, e_rdata;
  logic              v_we;
  logic [VW-1:0]     v_waddr, v_raddr;
  logic [VMEM_W-1:0] v_wdata, v_rdata;

  // Fields of the edge read back
  logic [ssp_pkg::VID_W-1:0] er_from, er_to;
  logic [WEIGHT_BITS-1:0]    er_w;
  logic [SUM_W-1:0]          sum;
  logic [ssp_pkg::DIST_W-1:0] sat_sum, rd_dist;
  logic                      acc_in, is_solve, edge_hit, improve;

  assign {er_from, er_to, er_w} = e_rdata;
  assign rd_dist = v_rdata[VMEM_W-1 -: ssp_pkg::DIST_W];
  assign sum     = SUM_W'(best_d) + SUM_W'(er_w);
  assign sat_sum = (sum > SUM_W'(ssp_pkg::DIST_MAX)) ? ssp_pkg::DIST_MAX
                                                     : sum[ssp_pkg::DIST_W-1:0];
  assign items.ready = (state == ssp_pkg::ST_IDLE);
  assign acc_in   = items.valid && items.ready;
  assign is_solve = (items.payload.opcode == ssp_pkg::OP_SOLVE);
  assign results.valid   = res_valid;
  assign results.payload = res;

  // Clamp the configured vertex count into 1..MAX_VERTICES
  always_comb begin
    if (vertex_count == '0) begin
      n_act = ssp_pkg::CNT_W'(1);
    end else if (vertex_count > MAXV_CNT) begin
      n_act = MAXV_CNT;
    end else begin
      n_act = vertex_count;
    end
  end

  // Edge qualifies: from the settled vertex, into an unsettled active vertex
  assign edge_hit = (er_from == ssp_pkg::VID_W'(best_u)) &&
                    (ssp_pkg::CNT_W'(er_to) < n) && !settled[er_to[VW-1:0]];
  assign improve  = !reached[cur_to[VW-1:0]] || (nd < rd_dist);

  always_comb begin
    e_we    = acc_in && !is_solve && (edge_total < MAXE_CNT);
    e_addr  = e_we ? edge_total[EW-1:0] : ecnt[EW-1:0];
    e_wdata = {items.payload.source_vertex, items.payload.sink_vertex,
               WEIGHT_BITS'(items.payload.weight)};
    v_we    = 1'b0;
    v_waddr = cur_to[VW-1:0];
    v_wdata = {nd, ssp_pkg::VID_W'(best_u)};
    v_raddr = cnt[VW-1:0];
    if (acc_in && is_solve && (ssp_pkg::CNT_W'(items.payload.source_vertex) < n_act)) begin
      v_we    = 1'b1;
      v_waddr = items.payload.source_vertex[VW-1:0];
      v_wdata = '0;
    end else if (state == ssp_pkg::ST_RELAX_UP) begin
      v_we = improve;
    end
    if (state == ssp_pkg::ST_RELAX_CK) begin
      v_raddr = er_to[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (e_we) begin
      edge_mem[e_addr] <= e_wdata;
    end
    e_rdata <= edge_mem[e_addr];
  end

  always_ff @(posedge clk) begin
    if (v_we) begin
      vert_mem[v_waddr] <= v_wdata;
    end
    v_rdata <= vert_mem[v_raddr];
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= MAXV_CNT;
    end else if (cfg_we) begin
      vertex_count <= cfg_data;
    end
  end

  // Solve sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ssp_pkg::ST_IDLE;
      edge_total <= '0;
      overflow   <= 1'b0;
      reached    <= '0;
      settled    <= '0;
      res_valid  <= 1'b0;
      rd_pend    <= 1'b0;
      found      <= 1'b0;
      cnt        <= '0;
      ecnt       <= '0;
    end else begin
      unique case (state)
        ssp_pkg::ST_IDLE: begin
          if (acc_in && !is_solve) begin
            if (edge_total < MAXE_CNT) begin
              edge_total <= edge_total + ET_W'(1);
            end else begin
              overflow <= 1'b1;
            end
          end else if (acc_in) begin
            n       <= n_act;
            start   <= items.payload.source_vertex;
            settled <= '0;
            // Mark only the start, and only when it lies in the active range
            if (ssp_pkg::CNT_W'(items.payload.source_vertex) < n_act) begin
              reached <= MAX_VERTICES'(1) << items.payload.source_vertex[VW-1:0];
            end else begin
              reached <= '0;
            end
            cnt     <= '0;
            found   <= 1'b0;
            rd_pend <= 1'b0;
            state   <= ssp_pkg::ST_SCAN;
          end
        end
        ssp_pkg::ST_SCAN: begin
          // Issue one vertex read per cycle, compare the previous one
          if (cnt < n) begin
            rd_pend <= 1'b1;
            rd_v    <= cnt;
            cnt     <= cnt + ssp_pkg::CNT_W'(1);
          end else begin
            rd_pend <= 1'b0;
          end
          if (rd_pend && reached[rd_v[VW-1:0]] && !settled[rd_v[VW-1:0]] &&
              (!found || rd_dist < best_d)) begin
            found  <= 1'b1;
            best_u <= rd_v[VW-1:0];
            best_d <= rd_dist;
          end
          if (cnt == n && !rd_pend) begin
            if (found) begin
              settled[best_u] <= 1'b1;
              ecnt  <= '0;
              state <= ssp_pkg::ST_RELAX_RD;
            end else begin
              cnt   <= '0;
              state <= ssp_pkg::ST_OUT_RD;
            end
          end
        end
        ssp_pkg::ST_RELAX_RD: begin
          if (ecnt < edge_total) begin
            state <= ssp_pkg::ST_RELAX_CK;
          end else begin
            cnt   <= '0;
            found <= 1'b0;
            state <= ssp_pkg::ST_SCAN;
          end
        end
        ssp_pkg::ST_RELAX_CK: begin
          if (edge_hit) begin
            cur_to <= er_to;
            nd     <= sat_sum;
            state  <= ssp_pkg::ST_RELAX_UP;
          end else begin
            ecnt  <= ecnt + ET_W'(1);
            state <= ssp_pkg::ST_RELAX_RD;
          end
        end
        ssp_pkg::ST_RELAX_UP: begin
          if (improve) begin
            reached[cur_to[VW-1:0]] <= 1'b1;
          end
          ecnt  <= ecnt + ET_W'(1);
          state <= ssp_pkg::ST_RELAX_RD;
        end
        ssp_pkg::ST_OUT_RD: begin
          state <= ssp_pkg::ST_OUT_WAIT;
        end
        ssp_pkg::ST_OUT_WAIT: begin
          // Load the output register once, then hold until taken
          if (!res_valid) begin
            res_valid <= 1'b1;
          end else if (results.ready) begin
            res_valid <= 1'b0;
            if (cnt + ssp_pkg::CNT_W'(1) == n) begin
              state <= ssp_pkg::ST_IDLE;
            end else begin
              cnt   <= cnt + ssp_pkg::CNT_W'(1);
              state <= ssp_pkg::ST_OUT_RD;
            end
          end
        end
        default: state <= ssp_pkg::ST_IDLE;
      endcase
    end
  end

  // Result payload, captured when the vertex read returns
  always_ff @(posedge clk) begin
    if (state == ssp_pkg::ST_OUT_WAIT && !res_valid) begin
      res.vertex_index    <= cnt[ssp_pkg::VID_W-1:0];
      res.reachable       <= reached[cnt[VW-1:0]];
      res.distance        <= reached[cnt[VW-1:0]] ? rd_dist : '0;
      res.has_predecessor <= reached[cnt[VW-1:0]] && (cnt[ssp_pkg::VID_W-1:0] != start);
      res.predecessor     <= (reached[cnt[VW-1:0]] && (cnt[ssp_pkg::VID_W-1:0] != start))
                             ? v_rdata[ssp_pkg::VID_W-1:0] : '0;
      res.edge_overflow   <= overflow;
      res.last            <= (cnt + ssp_pkg::CNT_W'(1) == n);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/ssp_checker.sv =====
// Port-level checks of the shortest-path unit, bound to the top level.
// Depends on ssp_pkg and single_source_shortest_path_unit_macros.svh.
`default_nettype none
`include "single_source_shortest_path_unit_macros.svh"
module ssp_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire ssp_pkg::out_item_t out_payload
);
  // A stalled result holds
  `SSP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload))
  // No new transaction taken while results are pending
  `SSP_ASSERT_NOW(a_busy_out, out_valid, !in_ready)
  // More results follow a non-final one, so input stays blocked
  `SSP_ASSERT_NEXT(a_mid_solve, out_valid && out_ready && !out_payload.last, !in_ready)
  // Nothing is offered right after reset
  `SSP_ASSERT_NOW(a_rst_quiet, $past(rst), !out_valid)
endmodule

bind single_source_shortest_path_unit ssp_checker u_ssp_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(items.ready),
  .out_valid(results.valid),
  .out_ready(results.ready),
  .out_payload(results.payload)
);
`default_nettype wire
